>>> hdl/gamma_curve_pixel_map_macros.svh
// ----------------------------------------------------------------------------
// Gamma curve pixel map: assertion macros
// Shared concurrent assertion forms for a fixed-latency pipeline.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CURVE_PIXEL_MAP_MACROS_SVH
`define GAMMA_CURVE_PIXEL_MAP_MACROS_SVH

// Cause must be followed by effect at exactly the delay given by dly
`define GCPM_ASSERT_DELAY(label, clk, rst_n, cause, dly, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cause) |-> ##dly (effect)) \
    else $error("gcpm: expected response missing after fixed latency");

// Effect may only appear when cause was seen exactly the delay given by dly before
`define GCPM_ASSERT_PAST(label, clk, rst_n, effect, cause, dly) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (effect) |-> $past(cause, dly)) \
    else $error("gcpm: response without matching earlier cause");

`endif

>>> hdl/gcpm_pkg.sv
// ----------------------------------------------------------------------------
// Gamma curve pixel map: package
// Widths, constants, the control word that rides the pipeline, and the
// table of powers of 255 used as divisors.
// ----------------------------------------------------------------------------
package gcpm_pkg;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned GAMMA_W   = 9;
  localparam int unsigned EXP_W     = 3;
  localparam int unsigned FRAC_W    = 7;
  localparam int unsigned POW_W     = 48;  // holds 254^6
  localparam int unsigned DIV_W     = 40;  // holds 255^5
  localparam int unsigned BLEND_W   = 15;  // holds 255*100
  localparam int unsigned SCALED_W  = 28;  // BLEND_W + reciprocal width

  // Integer part of gamma tops out at five for a 9-bit register
  localparam int unsigned EXP_MAX   = 5;
  localparam int unsigned QUO_BITS  = LEVEL_W;

  localparam logic [GAMMA_W-1:0] GAMMA_SCALE = 9'd100;
  localparam logic [FRAC_W-1:0]  FRAC_SCALE  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

  // floor(v/100) == (v*5243) >> 19 for v below 25600
  localparam logic [12:0]        RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;

  // Accept edge to the edge that takes the result
  localparam int unsigned LATENCY = 18;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [EXP_W-1:0]   exp_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [POW_W-1:0]   pow_t;
  typedef logic [DIV_W-1:0]   div_t;

  typedef struct packed {
    logic  zero;      // input level was zero
    logic  exp_zero;  // integer part of gamma is zero
    frac_t frac;      // fractional part in hundredths
  } ctl_t;

  // 255^k for k = 0..5
  function automatic div_t pow255(input exp_t k);
    div_t r;
    unique case (k)
      3'd0:    r = 40'd1;
      3'd1:    r = 40'd255;
      3'd2:    r = 40'd65025;
      3'd3:    r = 40'd16581375;
      3'd4:    r = 40'd4228250625;
      3'd5:    r = 40'd1078203909375;
      default: r = 40'd1;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/gcpm_power.sv
// ----------------------------------------------------------------------------
// Gamma curve pixel map: power chain
// Multiplies the level into a running power once per stage and captures
// x^n and x^(n+1) as they pass.
// ----------------------------------------------------------------------------
module gcpm_power
  import gcpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  level_t level_i,
  input  exp_t   exp_i,
  input  ctl_t   ctl_i,
  output logic   valid_o,
  output pow_t   pow_n_o,
  output pow_t   pow_n1_o,
  output exp_t   exp_o,
  output ctl_t   ctl_o
);

  localparam int unsigned STAGES = EXP_MAX;

  logic   valid_q [0:STAGES];
  pow_t   pow_q   [0:STAGES];
  pow_t   pn_q    [0:STAGES];
  pow_t   pn1_q   [0:STAGES];
  level_t x_q     [0:STAGES];
  exp_t   exp_q   [0:STAGES];
  ctl_t   ctl_q   [0:STAGES];

  // Load stage zero with x^1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pow_q[0] <= pow_t'(level_i);
    pn_q[0]  <= (exp_i == 3'd1) ? pow_t'(level_i) : '0;
    pn1_q[0] <= (exp_i == 3'd0) ? pow_t'(level_i) : '0;
    x_q[0]   <= level_i;
    exp_q[0] <= exp_i;
    ctl_q[0] <= ctl_i;
  end

  // Each stage raises the power by one and picks off the wanted ones
  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    pow_t pow_d;

    assign pow_d = pow_q[s-1] * pow_t'(x_q[s-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      pow_q[s] <= pow_d;
      pn_q[s]  <= (exp_q[s-1] == EXP_W'(s + 1)) ? pow_d : pn_q[s-1];
      pn1_q[s] <= (exp_q[s-1] == EXP_W'(s))     ? pow_d : pn1_q[s-1];
      x_q[s]   <= x_q[s-1];
      exp_q[s] <= exp_q[s-1];
      ctl_q[s] <= ctl_q[s-1];
    end
  end

  assign valid_o  = valid_q[STAGES];
  assign pow_n_o  = pn_q[STAGES];
  assign pow_n1_o = pn1_q[STAGES];
  assign exp_o    = exp_q[STAGES];
  assign ctl_o    = ctl_q[STAGES];

endmodule

>>> hdl/gcpm_divide.sv
// ----------------------------------------------------------------------------
// Gamma curve pixel map: divider
// Two restoring dividers side by side, one quotient bit per stage, that
// divide x^n by 255^(n-1) and x^(n+1) by 255^n. Both quotients fit 8 bits.
// ----------------------------------------------------------------------------
module gcpm_divide
  import gcpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  pow_t   pow_n_i,
  input  pow_t   pow_n1_i,
  input  exp_t   exp_i,
  input  ctl_t   ctl_i,
  output logic   valid_o,
  output level_t y_n_o,
  output level_t y_n1_o,
  output ctl_t   ctl_o
);

  localparam int unsigned STAGES = QUO_BITS;

  logic   valid_q [0:STAGES];
  pow_t   rem_a_q [0:STAGES];
  pow_t   rem_b_q [0:STAGES];
  level_t quo_a_q [0:STAGES];
  level_t quo_b_q [0:STAGES];
  exp_t   exp_a_q [0:STAGES];
  exp_t   exp_b_q [0:STAGES];
  ctl_t   ctl_q   [0:STAGES];

  // Register the dividends and the divisor exponents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_a_q[0] <= pow_n_i;
    rem_b_q[0] <= pow_n1_i;
    quo_a_q[0] <= '0;
    quo_b_q[0] <= '0;
    exp_a_q[0] <= (exp_i == '0) ? '0 : exp_i - 3'd1;
    exp_b_q[0] <= exp_i;
    ctl_q[0]   <= ctl_i;
  end

  // Try the shifted divisor, subtract on success, shift the bit in
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int unsigned SH = STAGES - 1 - j;
    pow_t shf_a;
    pow_t shf_b;
    logic ge_a;
    logic ge_b;

    assign shf_a = pow_t'(pow255(exp_a_q[j])) << SH;
    assign shf_b = pow_t'(pow255(exp_b_q[j])) << SH;
    assign ge_a  = (rem_a_q[j] >= shf_a);
    assign ge_b  = (rem_b_q[j] >= shf_b);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[j+1] <= ge_a ? rem_a_q[j] - shf_a : rem_a_q[j];
      rem_b_q[j+1] <= ge_b ? rem_b_q[j] - shf_b : rem_b_q[j];
      quo_a_q[j+1] <= {quo_a_q[j][LEVEL_W-2:0], ge_a};
      quo_b_q[j+1] <= {quo_b_q[j][LEVEL_W-2:0], ge_b};
      exp_a_q[j+1] <= exp_a_q[j];
      exp_b_q[j+1] <= exp_b_q[j];
      ctl_q[j+1]   <= ctl_q[j];
    end
  end

  assign valid_o = valid_q[STAGES];
  assign y_n_o   = quo_a_q[STAGES];
  assign y_n1_o  = quo_b_q[STAGES];
  assign ctl_o   = ctl_q[STAGES];

endmodule

>>> hdl/gcpm_blend.sv
// ----------------------------------------------------------------------------
// Gamma curve pixel map: blend
// Weights the two curve points by the gamma fraction, divides by 100
// through a reciprocal multiply, clamps and forces zero for a zero level.
// ----------------------------------------------------------------------------
module gcpm_blend
  import gcpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  level_t y_n_i,
  input  level_t y_n1_i,
  input  ctl_t   ctl_i,
  output logic   valid_o,
  output level_t level_o
);

  logic [BLEND_W-1:0]  sum_d;
  logic [BLEND_W-1:0]  sum_q;
  logic [SCALED_W-1:0] scaled_d;
  logic [SCALED_W-1:0] scaled_q;
  logic [SCALED_W-RECIP_SHIFT-1:0] quo;
  level_t              level_d;
  level_t              level_q;
  level_t              y_lo;
  logic                zero1_q;
  logic                zero2_q;
  logic                valid1_q;
  logic                valid2_q;
  logic                valid3_q;

  // Weighted sum of the two curve points
  assign y_lo  = ctl_i.exp_zero ? LEVEL_MAX : y_n_i;
  assign sum_d = BLEND_W'(y_lo) * BLEND_W'(FRAC_SCALE - ctl_i.frac)
               + BLEND_W'(y_n1_i) * BLEND_W'(ctl_i.frac);

  // Divide by 100 as multiply and shift
  assign scaled_d = SCALED_W'(sum_q) * SCALED_W'(RECIP_100);

  // Clamp and apply the zero-level case
  assign quo = scaled_q[SCALED_W-1:RECIP_SHIFT];
  always_comb begin
    if (zero2_q) begin
      level_d = '0;
    end else if (quo > (SCALED_W-RECIP_SHIFT)'(LEVEL_MAX)) begin
      level_d = LEVEL_MAX;
    end else begin
      level_d = quo[LEVEL_W-1:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // Data stages
  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    zero1_q  <= ctl_i.zero;
    scaled_q <= scaled_d;
    zero2_q  <= zero1_q;
    level_q  <= level_d;
  end

  assign valid_o = valid3_q;
  assign level_o = level_q;

endmodule

>>> hdl/gamma_curve_pixel_map.sv
// ----------------------------------------------------------------------------
// Gamma curve pixel map: top level
// Maps an 8-bit level through a gamma curve set in hundredths.
// ----------------------------------------------------------------------------
// Throughput: one item per clock; busy stays low, nothing in the pipe stalls.
// The depth is six power chain stages, nine divider stages and three blend stages.
// Reset clears all pipeline valid bits and sets gamma to 1.00.
`include "gamma_curve_pixel_map_macros.svh"

module gamma_curve_pixel_map
  import gcpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  level_t             level_in_i,
  output logic               valid_o,
  output level_t             level_out_o,
  input  logic               gamma_we_i,
  input  logic [GAMMA_W-1:0] gamma_hundredths_i
);

  exp_t   exp_q;
  exp_t   exp_d;
  frac_t  frac_q;
  frac_t  frac_d;
  logic   accept;
  ctl_t   ctl_in;

  logic   pw_valid;
  pow_t   pw_n;
  pow_t   pw_n1;
  exp_t   pw_exp;
  ctl_t   pw_ctl;

  logic   dv_valid;
  level_t dv_y_n;
  level_t dv_y_n1;
  ctl_t   dv_ctl;

  // Split the written gamma into integer part and hundredths
  always_comb begin
    if (gamma_hundredths_i >= 9'(5 * GAMMA_SCALE)) begin
      exp_d = 3'd5;
    end else if (gamma_hundredths_i >= 9'(4 * GAMMA_SCALE)) begin
      exp_d = 3'd4;
    end else if (gamma_hundredths_i >= 9'(3 * GAMMA_SCALE)) begin
      exp_d = 3'd3;
    end else if (gamma_hundredths_i >= 9'(2 * GAMMA_SCALE)) begin
      exp_d = 3'd2;
    end else if (gamma_hundredths_i >= GAMMA_SCALE) begin
      exp_d = 3'd1;
    end else begin
      exp_d = 3'd0;
    end
    frac_d = FRAC_W'(gamma_hundredths_i - 9'(GAMMA_SCALE * GAMMA_W'(exp_d)));
  end

  // Hold the decoded gamma
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 3'd1;
      frac_q <= '0;
    end else if (gamma_we_i) begin
      exp_q  <= exp_d;
      frac_q <= frac_d;
    end
  end

  // Take an item on every start
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ctl_in.zero     = (level_in_i == '0);
  assign ctl_in.exp_zero = (exp_q == '0);
  assign ctl_in.frac     = frac_q;

  gcpm_power u_power (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .level_i  (level_in_i),
    .exp_i    (exp_q),
    .ctl_i    (ctl_in),
    .valid_o  (pw_valid),
    .pow_n_o  (pw_n),
    .pow_n1_o (pw_n1),
    .exp_o    (pw_exp),
    .ctl_o    (pw_ctl)
  );

  gcpm_divide u_divide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pw_valid),
    .pow_n_i  (pw_n),
    .pow_n1_i (pw_n1),
    .exp_i    (pw_exp),
    .ctl_i    (pw_ctl),
    .valid_o  (dv_valid),
    .y_n_o    (dv_y_n),
    .y_n1_o   (dv_y_n1),
    .ctl_o    (dv_ctl)
  );

  gcpm_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .y_n_i    (dv_y_n),
    .y_n1_i   (dv_y_n1),
    .ctl_i    (dv_ctl),
    .valid_o  (valid_o),
    .level_o  (level_out_o)
  );

  // Every item comes out after the fixed latency, and nothing else does
  `GCPM_ASSERT_DELAY(a_item_out, clk_i, rst_ni, accept, LATENCY, valid_o)
  `GCPM_ASSERT_PAST(a_no_spurious, clk_i, rst_ni, valid_o, accept, LATENCY)
  // A zero level maps to zero whatever the gamma
  `GCPM_ASSERT_DELAY(a_zero_level, clk_i, rst_ni, accept && ctl_in.zero, LATENCY, level_out_o == '0)

endmodule
